@@ sv/latency_histogram_engine_assert.svh @@
`ifndef LATENCY_HISTOGRAM_ENGINE_ASSERT_SVH
`define LATENCY_HISTOGRAM_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define LHE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("latency histogram assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define LHE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("latency histogram assertion failed");

`endif

@@ sv/lhe_pkg.sv @@
package lhe_pkg;

  localparam int SAMPLE_W   = 48;
  localparam int NS_W       = 48;
  localparam int Q_W        = 24;
  localparam int PCT_W      = 17;
  localparam int BIDX_W     = 3;
  localparam int TOTAL_W    = 40;
  localparam int SUM_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int NUM_BUCKETS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 40;

  localparam logic [NS_W-1:0] NS_MAX = '1;
  localparam logic [Q_W-1:0] NS_PER_CYCLE_RESET = 24'h01_0000;

  localparam logic [CFG_IDX_W-1:0] REG_NS_PER_CYCLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_BASE   = 3'd1;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic accept;
    logic conv;
    logic classify;
    logic commit;
    logic tgt;
    logic walk;
    logic answer;
  } lhe_cmd_t;

  typedef struct packed {
    logic empty;
    logic walk_hit;
  } lhe_stat_t;

  function automatic logic [NS_W-1:0] bound_reset(input int idx);
    logic [NS_W-1:0] v;
    case (idx)
      0: v = 48'd1000;
      1: v = 48'd2000;
      2: v = 48'd5000;
      3: v = 48'd10000;
      4: v = 48'd50000;
      5: v = 48'd100000;
      6: v = 48'd1000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/lhe_in_if.sv @@
interface lhe_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [lhe_pkg::SAMPLE_W-1:0] sample_cycles;
  logic [lhe_pkg::PCT_W-1:0]    percentile_q16;

  modport source (output valid, command, sample_cycles, percentile_q16, input ready);
  modport sink (input valid, command, sample_cycles, percentile_q16, output ready);
endinterface

@@ sv/lhe_out_if.sv @@
interface lhe_out_if;
  logic                        valid;
  logic                        ready;
  logic [lhe_pkg::NS_W-1:0]    sample_ns;
  logic [lhe_pkg::BIDX_W-1:0]  bucket_index;
  logic [lhe_pkg::NS_W-1:0]    percentile_ns;
  logic [lhe_pkg::TOTAL_W-1:0] total_samples;
  logic [lhe_pkg::SUM_W-1:0]   sum_ns;
  logic [lhe_pkg::NS_W-1:0]    min_ns;
  logic [lhe_pkg::NS_W-1:0]    max_ns;

  modport source (output valid, sample_ns, bucket_index, percentile_ns, total_samples,
                  sum_ns, min_ns, max_ns, input ready);
  modport sink (input valid, sample_ns, bucket_index, percentile_ns, total_samples,
                sum_ns, min_ns, max_ns, output ready);
endinterface

@@ sv/lhe_datapath.sv @@
module lhe_datapath #(
  parameter int NUM_BUCKETS = lhe_pkg::NUM_BUCKETS_DEF,
  parameter int COUNT_WIDTH = lhe_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lhe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lhe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [lhe_pkg::SAMPLE_W-1:0]   in_sample_cycles,
  input  logic [lhe_pkg::PCT_W-1:0]      in_percentile_q16,
  input  lhe_pkg::lhe_cmd_t              cmd,
  output lhe_pkg::lhe_stat_t             stat,
  output logic [lhe_pkg::NS_W-1:0]       sample_ns,
  output logic [lhe_pkg::BIDX_W-1:0]     bucket_index,
  output logic [lhe_pkg::NS_W-1:0]       percentile_ns,
  output logic [lhe_pkg::TOTAL_W-1:0]    total_samples,
  output logic [lhe_pkg::SUM_W-1:0]      sum_ns,
  output logic [lhe_pkg::NS_W-1:0]       min_ns,
  output logic [lhe_pkg::NS_W-1:0]       max_ns
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int NBND  = NUM_BUCKETS - 1;
  localparam int IW    = lhe_pkg::CFG_IDX_W;
  localparam int BW    = lhe_pkg::BIDX_W;
  localparam int TW    = lhe_pkg::TOTAL_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BUCKETS - 1);

  logic [lhe_pkg::Q_W-1:0]   ncq_r;
  logic [lhe_pkg::NS_W-1:0]  bound_r [NBND];

  logic [47:0]               prod_hi_r;
  logic [47:0]               prod_lo_r;
  logic [48:0]               tph_r;
  logic [48:0]               tpl_r;
  logic [56:0]               conv_sum;
  logic [lhe_pkg::NS_W-1:0]  conv_sat;
  logic [lhe_pkg::NS_W-1:0]  sample_ns_r;
  logic [IDX_W-1:0]          idx_r;
  logic [IDX_W-1:0]          class_idx;

  logic [COUNT_WIDTH-1:0]    count_r [NUM_BUCKETS];
  logic [COUNT_WIDTH-1:0]    cnt_rd;
  logic [COUNT_WIDTH-1:0]    cnt_inc;
  logic [COUNT_WIDTH-1:0]    total_r;
  logic [COUNT_WIDTH-1:0]    total_nxt;
  logic [63:0]               total64;
  logic [lhe_pkg::SUM_W-1:0] sum_r;
  logic [lhe_pkg::SUM_W-1:0] sum_nxt;
  logic [lhe_pkg::NS_W-1:0]  min_r;
  logic [lhe_pkg::NS_W-1:0]  min_nxt;
  logic [lhe_pkg::NS_W-1:0]  max_r;
  logic [lhe_pkg::NS_W-1:0]  max_nxt;

  logic [64:0]               tsum;
  logic [63:0]               tgt_sat;
  logic [63:0]               target_r;
  logic [63:0]               cum_r;
  logic [64:0]               cum_sum;
  logic [63:0]               cum_nxt;
  logic                      walk_hit;
  logic [lhe_pkg::NS_W-1:0]  bnd_sel;

  logic [lhe_pkg::NS_W-1:0]    res_sample_ns_r;
  logic [BW-1:0]               res_bidx_r;
  logic [lhe_pkg::NS_W-1:0]    res_pct_r;
  logic [TW-1:0]               res_total_r;
  logic [lhe_pkg::SUM_W-1:0]   res_sum_r;
  logic [lhe_pkg::NS_W-1:0]    res_min_r;
  logic [lhe_pkg::NS_W-1:0]    res_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncq_r <= lhe_pkg::NS_PER_CYCLE_RESET;
      for (int b = 0; b < NBND; b++) begin
        bound_r[b] <= lhe_pkg::bound_reset(b);
      end
    end else if (cfg_we) begin
      if (cfg_index == lhe_pkg::REG_NS_PER_CYCLE) begin
        ncq_r <= cfg_data[lhe_pkg::Q_W-1:0];
      end
      for (int b = 0; b < NBND; b++) begin
        if (cfg_index == IW'(lhe_pkg::REG_BOUND_BASE + b)) begin
          bound_r[b] <= cfg_data[lhe_pkg::NS_W-1:0];
        end
      end
    end
  end

  assign total64 = 64'(total_r);

  // The products of a beat are registered as it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_hi_r <= in_sample_cycles[47:24] * ncq_r;
      prod_lo_r <= in_sample_cycles[23:0] * ncq_r;
      tph_r     <= in_percentile_q16 * total64[63:32];
      tpl_r     <= in_percentile_q16 * total64[31:0];
    end
  end

  assign conv_sum = {1'b0, prod_hi_r, 8'd0} + 57'(prod_lo_r[47:16]);
  assign conv_sat = (|conv_sum[56:48]) ? lhe_pkg::NS_MAX : conv_sum[47:0];

  always_comb begin
    class_idx = LAST;
    for (int b = NBND - 1; b >= 0; b--) begin
      if (sample_ns_r < bound_r[b]) begin
        class_idx = IDX_W'(b);
      end
    end
  end

  assign cnt_rd    = count_r[idx_r];
  assign cnt_inc   = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
  assign total_nxt = (&total_r) ? total_r : total_r + 1'b1;
  assign sum_nxt   = sum_r + 64'(sample_ns_r);
  assign min_nxt   = (sample_ns_r < min_r) ? sample_ns_r : min_r;
  assign max_nxt   = (sample_ns_r > max_r) ? sample_ns_r : max_r;

  assign tsum    = {1'b0, tph_r[47:0], 16'd0} + 65'(tpl_r[48:16]);
  assign tgt_sat = (tph_r[48] || tsum[64]) ? '1 : tsum[63:0];

  assign cum_sum  = {1'b0, cum_r} + 65'(cnt_rd);
  assign cum_nxt  = cum_sum[64] ? '1 : cum_sum[63:0];
  assign walk_hit = (cum_nxt >= target_r) || (idx_r == LAST);

  always_comb begin
    bnd_sel = lhe_pkg::NS_MAX;
    for (int b = 0; b < NBND; b++) begin
      if (idx_r == IDX_W'(b)) begin
        bnd_sel = bound_r[b];
      end
    end
  end

  assign stat.empty    = (total_r == '0);
  assign stat.walk_hit = walk_hit;

  always_ff @(posedge clk) begin
    if (cmd.conv) begin
      sample_ns_r <= conv_sat;
    end
    if (cmd.classify) begin
      idx_r <= class_idx;
    end else if (cmd.tgt) begin
      idx_r <= '0;
    end else if (cmd.walk && !walk_hit) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.tgt) begin
      target_r <= tgt_sat;
      cum_r    <= '0;
    end else if (cmd.walk) begin
      cum_r <= cum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        count_r[b] <= '0;
      end
      total_r <= '0;
      sum_r   <= '0;
      min_r   <= lhe_pkg::NS_MAX;
      max_r   <= '0;
    end else if (cmd.commit) begin
      count_r[idx_r] <= cnt_inc;
      total_r        <= total_nxt;
      sum_r          <= sum_nxt;
      min_r          <= min_nxt;
      max_r          <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_sample_ns_r <= sample_ns_r;
      res_bidx_r      <= BW'(idx_r);
      res_pct_r       <= '0;
      res_total_r     <= TW'(total_nxt);
      res_sum_r       <= sum_nxt;
      res_min_r       <= min_nxt;
      res_max_r       <= max_nxt;
    end else if (cmd.answer) begin
      res_sample_ns_r <= '0;
      res_bidx_r      <= stat.empty ? '0 : BW'(idx_r);
      res_pct_r       <= stat.empty ? '0 : bnd_sel;
      res_total_r     <= TW'(total_r);
      res_sum_r       <= sum_r;
      res_min_r       <= min_r;
      res_max_r       <= max_r;
    end
  end

  assign sample_ns     = res_sample_ns_r;
  assign bucket_index  = res_bidx_r;
  assign percentile_ns = res_pct_r;
  assign total_samples = res_total_r;
  assign sum_ns        = res_sum_r;
  assign min_ns        = res_min_r;
  assign max_ns        = res_max_r;

endmodule

@@ sv/lhe_ctrl.sv @@
module lhe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  lhe_pkg::lhe_stat_t stat,
  output lhe_pkg::lhe_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CONV   = 7'b0000010,
    S_CLASS  = 7'b0000100,
    S_COMMIT = 7'b0001000,
    S_TSUM   = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_ANSWER = 7'b1000000
  } lhe_state_t;

  lhe_state_t state_r;
  lhe_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;
  logic       load;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = rst_n;
        cmd.accept = in_valid && rst_n;
        if (in_valid && rst_n) begin
          state_nxt = (in_command == lhe_pkg::CMD_QUERY) ? S_TSUM : S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_TSUM: begin
        cmd.tgt   = 1'b1;
        state_nxt = stat.empty ? S_ANSWER : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_hit) begin
          state_nxt = S_ANSWER;
        end
      end
      S_ANSWER: begin
        if (slot_free) begin
          cmd.answer = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign load          = cmd.commit || cmd.answer;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/latency_histogram_engine.sv @@
// Latency histogram with percentile query. Each input beat either records a
// cycle count (converted to nanoseconds with the Q8.16 ns-per-cycle register
// and binned against the bucket bounds) or asks for the bucket bound at a Q1.16
// percentile; every beat returns one result beat carrying the statistics after
// it. One beat is worked on at a time. A record passes through the product,
// conversion, bucket search and counter update before its result. A query
// computes its target and walks the cumulative counts over 1 to NUM_BUCKETS
// buckets, one counter per cycle; on an empty histogram it skips the walk.
// The result sits in an output register, so the next beat is taken while it
// waits; a finished beat stalls only while the previous result has not been
// taken. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, which the block does
// not enforce. Counters and configuration return to their defaults on reset.
`include "latency_histogram_engine_assert.svh"

module latency_histogram_engine #(
  parameter int NUM_BUCKETS = lhe_pkg::NUM_BUCKETS_DEF,
  parameter int COUNT_WIDTH = lhe_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lhe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lhe_pkg::CFG_DATA_W-1:0] cfg_data,
  lhe_in_if.sink                         in_ch,
  lhe_out_if.source                      out_ch
);

  lhe_pkg::lhe_cmd_t  cmd;
  lhe_pkg::lhe_stat_t stat;

  lhe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  lhe_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_cycles  (in_ch.sample_cycles),
    .in_percentile_q16 (in_ch.percentile_q16),
    .cmd               (cmd),
    .stat              (stat),
    .sample_ns         (out_ch.sample_ns),
    .bucket_index      (out_ch.bucket_index),
    .percentile_ns     (out_ch.percentile_ns),
    .total_samples     (out_ch.total_samples),
    .sum_ns            (out_ch.sum_ns),
    .min_ns            (out_ch.min_ns),
    .max_ns            (out_ch.max_ns)
  );

  `LHE_ASSERT_IMP(a_one_action, 1'b1, $onehot0(cmd))
  `LHE_ASSERT_NXT(a_result_shown, cmd.commit || cmd.answer, out_ch.valid)
  `LHE_ASSERT_NXT(a_busy_after_beat, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule
